>>> rtl/ldcs_pkg.sv
// ----------------------------------------------------------------------------
// LED driver chain scan-out package
// Action codes and the command/status bundles shared by controller and datapath.
// ----------------------------------------------------------------------------
package ldcs_pkg;

  localparam int WORD_W = 16;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_REFRESH = 2'd1,
    ACT_BCAST   = 2'd2,
    ACT_NOP     = 2'd3
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;    // write zeros at the sweep address and advance it
    logic ld;     // capture the input item and seed the divider
    logic div;    // one subtract step of the divider
    logic wr;     // store the captured pixel
    logic issue;  // read the frame for the current chip and advance the chip count
  } ldcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic slot_free;
    logic last_chip;
    logic pend;
    logic wr_ok;
    logic rf_ok;
  } ldcs_sts_t;

endpackage

>>> rtl/ldcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ldcs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ldcs_dp.sv
// ----------------------------------------------------------------------------
// LED driver chain scan-out datapath
// Frame storage in bit lanes, the shared column divider, the chip counter,
// the read slot and the output register.
// ----------------------------------------------------------------------------
module ldcs_dp
  import ldcs_pkg::*;
#(
  parameter int CHIPS         = 32,
  parameter int COLS_PER_CHIP = 6,
  parameter int DIGITS        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ldcs_cmd_t         cmd,
  output ldcs_sts_t         sts,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_pix_x,
  input  logic [3:0]        in_pix_y,
  input  logic              in_pix_on,
  input  logic [2:0]        in_digit_sel,
  input  logic [15:0]       in_command,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_word,
  output logic              out_last
);

  localparam int C          = COLS_PER_CHIP;
  localparam int W          = CHIPS * COLS_PER_CHIP;
  localparam int CW         = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int RW         = $clog2(DIGITS);
  localparam int AW         = RW + CW;
  localparam int MAIN_DEPTH = DIGITS * (2 ** CW);
  localparam int TOP_DEPTH  = 2 ** CW;
  localparam int DW         = ($clog2(W) > 3) ? $clog2(W) : 3;

  logic [AW-1:0]     sweep_r;
  logic              mode_rf_r;
  logic [2:0]        d_r;
  logic [15:0]       cmd_r;
  logic [3:0]        py_r;
  logic              pon_r;
  logic              b8_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     quo_r;
  logic [CW-1:0]     chip_r;
  logic              p_r;
  logic              p_last_r;
  logic              p_b8_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;

  logic              move;
  logic              wr_top;
  logic              wr_main;
  logic [C-1:0]      lane_sel;
  logic [C-1:0]      main_rd;
  logic [C-1:0]      top_rd;
  logic [AW-1:0]     main_waddr;
  logic [CW-1:0]     top_waddr;
  logic [2:0]        row_rf;
  logic [DW:0]       top_sum;
  logic              top_ok;
  logic [7:0]        val;
  logic [3:0]        dplus;
  logic [WORD_W-1:0] word_nxt;
  logic [DW-1:0]     div_seed;

  // Pixel column i of a chip group (i = x mod C) lives in lane i.
  assign wr_top     = cmd.wr && (py_r == 4'(DIGITS));
  assign wr_main    = cmd.wr && (py_r != 4'(DIGITS));
  assign main_waddr = cmd.clr ? sweep_r : {py_r[RW-1:0], quo_r[CW-1:0]};
  assign top_waddr  = cmd.clr ? sweep_r[CW-1:0] : quo_r[CW-1:0];
  assign row_rf     = 3'(DIGITS - 1) - d_r;
  assign top_sum    = (DW + 1)'(chip_r) + (DW + 1)'(quo_r);
  assign top_ok     = top_sum < (DW + 1)'(CHIPS);

  for (genvar g = 0; g < C; g++) begin : g_lane
    assign lane_sel[g] = (rem_r == DW'(C - 1 - g));

    ldcs_ram #(
      .WIDTH (1),
      .DEPTH (MAIN_DEPTH)
    ) u_main (
      .clk   (clk),
      .we    (cmd.clr || (wr_main && lane_sel[g])),
      .waddr (main_waddr),
      .wdata (pon_r && !cmd.clr),
      .re    (cmd.issue),
      .raddr ({row_rf[RW-1:0], chip_r}),
      .rdata (main_rd[g])
    );

    ldcs_ram #(
      .WIDTH (1),
      .DEPTH (TOP_DEPTH)
    ) u_top (
      .clk   (clk),
      .we    (cmd.clr || (wr_top && lane_sel[g])),
      .waddr (top_waddr),
      .wdata (pon_r && !cmd.clr),
      .re    (cmd.issue),
      .raddr (top_sum[CW-1:0]),
      .rdata (top_rd[g])
    );
  end

  always_comb begin
    val        = '0;
    val[C-1:0] = main_rd;
    val[C]     = p_b8_r && (|(top_rd & lane_sel));
  end

  assign dplus    = {1'b0, d_r} + 4'd1;
  assign word_nxt = mode_rf_r ? {4'h0, dplus, val} : cmd_r;

  assign div_seed = (act_t'(in_action) == ACT_WRITE) ? (DW'(W - 1) - DW'(in_pix_x)) :
                    (in_digit_sel >= 3'd2) ? (DW'(in_digit_sel) - DW'(2)) : '0;

  assign move = p_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      p_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        sweep_r <= sweep_r + AW'(1);
      end
      p_r         <= cmd.issue || (p_r && !move);
      out_valid_r <= move || (out_valid_r && out_stall);
    end

    if (cmd.ld) begin
      mode_rf_r <= (act_t'(in_action) == ACT_REFRESH);
      d_r       <= in_digit_sel;
      cmd_r     <= in_command;
      py_r      <= in_pix_y;
      pon_r     <= in_pix_on;
      b8_r      <= (in_digit_sel >= 3'd2);
      rem_r     <= div_seed;
      quo_r     <= '0;
      chip_r    <= '0;
    end else begin
      if (cmd.div) begin
        rem_r <= rem_r - DW'(C);
        quo_r <= quo_r + DW'(1);
      end
      if (cmd.issue) begin
        chip_r <= chip_r + CW'(1);
      end
    end

    if (cmd.issue) begin
      p_last_r <= (chip_r == CW'(CHIPS - 1));
      p_b8_r   <= b8_r && top_ok;
    end

    if (move) begin
      out_word_r <= word_nxt;
      out_last_r <= p_last_r;
    end
  end

  assign sts.clr_done  = (sweep_r == AW'(MAIN_DEPTH - 1));
  assign sts.div_done  = (rem_r < DW'(C));
  assign sts.slot_free = !p_r || move;
  assign sts.last_chip = (chip_r == CW'(CHIPS - 1));
  assign sts.pend      = p_r;
  assign sts.wr_ok     = (32'(in_pix_x) < 32'(W)) && (32'(in_pix_y) <= 32'(DIGITS));
  assign sts.rf_ok     = (32'(in_digit_sel) < 32'(DIGITS));

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/ldcs_ctrl.sv
// ----------------------------------------------------------------------------
// LED driver chain scan-out controller
// Sequences the clearing pass, pixel writes and the per-chip word runs.
// ----------------------------------------------------------------------------
module ldcs_ctrl
  import ldcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  input  ldcs_sts_t  sts,
  output ldcs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_STREAM,
    S_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  act_t   act_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.ld = in_valid;
        if (in_valid) begin
          case (act_t'(in_action))
            ACT_WRITE:   state_nxt = sts.wr_ok ? S_DIV : S_IDLE;
            ACT_REFRESH: state_nxt = sts.rf_ok ? S_DIV : S_IDLE;
            ACT_BCAST:   state_nxt = S_STREAM;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div = !sts.div_done;
        cmd.wr  = sts.div_done && (act_r == ACT_WRITE);
        if (sts.div_done) begin
          state_nxt = (act_r == ACT_WRITE) ? S_IDLE : S_STREAM;
        end
      end
      S_STREAM: begin
        cmd.issue = sts.slot_free;
        if (sts.slot_free && sts.last_chip) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pend) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      act_r   <= ACT_NOP;
    end else begin
      state_r <= state_nxt;
      if (cmd.ld) begin
        act_r <= act_t'(in_action);
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> rtl/led_driver_chain_scanout_unit.sv
// ----------------------------------------------------------------------------
// LED driver chain scan-out unit
// Frame buffer and word generator for a daisy chain of eight-digit LED drivers.
// ----------------------------------------------------------------------------
// The unit keeps a one-bit frame of CHIPS*COLS_PER_CHIP columns by DIGITS+1
// rows and turns it into the 16-bit words that are shifted into the chain.
// After reset the frame is cleared by a pass that writes one address a cycle
// over all DIGITS * 2**ceil(log2(CHIPS)) addresses (256 with the defaults);
// in_stall stays high until it is over. A write item is taken and then finds
// its chip number by repeated subtraction of COLS_PER_CHIP, one step for
// each chip group between the pixel and the far end of the frame, before
// the pixel is stored. A refresh or broadcast item gives CHIPS words, one
// per cycle while out_stall is low, since each word needs one read of the
// frame lanes; a broadcast keeps the unit busy through the set-up and the
// drain of the read slot. A refresh also passes through the divider, which
// finds the chip offset of its extra row bit; with narrow chip groups a
// high digit needs subtraction steps there as well. The final word of every
// run carries out_last. The output register lets the next item be taken
// while the last word still waits.
// Writes outside the frame, refreshes of a digit the chips do not have and
// the unused action code are taken and give no word.
module led_driver_chain_scanout_unit
  import ldcs_pkg::*;
#(
  parameter int CHIPS         = 32,
  parameter int COLS_PER_CHIP = 6,
  parameter int DIGITS        = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_pix_x,
  input  logic [3:0]  in_pix_y,
  input  logic        in_pix_on,
  input  logic [2:0]  in_digit_sel,
  input  logic [15:0] in_command,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_word,
  output logic        out_last
);

  ldcs_cmd_t cmd;
  ldcs_sts_t sts;

  // The controller owns sequencing; all storage and arithmetic sit in the datapath.
  ldcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ldcs_dp #(
    .CHIPS         (CHIPS),
    .COLS_PER_CHIP (COLS_PER_CHIP),
    .DIGITS        (DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_action),
    .in_pix_x     (in_pix_x),
    .in_pix_y     (in_pix_y),
    .in_pix_on    (in_pix_on),
    .in_digit_sel (in_digit_sel),
    .in_command   (in_command),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .out_last     (out_last)
  );

endmodule

>>> rtl/ldcs_chk.sv
// ----------------------------------------------------------------------------
// LED driver chain scan-out checker
// Port-level properties of the scan-out unit, bound to the top level.
// ----------------------------------------------------------------------------
module ldcs_chk
  import ldcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_word,
  input logic        out_last
);

  // The frame is being cleared right after reset, so no item is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> in_stall)
    else $error("item could be taken during the clearing pass");

  // A broadcast item always keeps the unit busy for its word run.
  a_bcast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (act_t'(in_action) == ACT_BCAST) |=> in_stall)
    else $error("unit idle right after a broadcast item");

  // With the unit idle and nothing shown, no word can appear next cycle.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("word appeared without a run in progress");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind led_driver_chain_scanout_unit ldcs_chk u_ldcs_chk (.*);
